/* sv/grfp_pkg.sv */
`default_nettype none

package grfp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;

  // Field widths
  localparam int DIM_W  = 7;   // grid and rectangle sizes in cells
  localparam int SIZE_W = 11;  // cell size in pixels
  localparam int CELL_W = 6;   // reported cell index
  localparam int POS_W  = 16;  // reported pixel position

  localparam logic [DIM_W-1:0]  GRID_DIM_RST  = 7'd64;
  localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 11'd16;
  localparam logic [POS_W-1:0]  POS_SAT       = 16'hFFFF;

endpackage

`default_nettype wire

/* sv/grfp_ram.sv */
`default_nettype none

module grfp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/grid_rect_first_fit_packer.sv */
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   ---------------------------------------------
// request   start_i & !busy_o         req_type_i, rect_cols_i, rect_rows_i
// result    done_o (one-cycle strobe) placed_o, cell_col_o, cell_row_o,
//                                     pixel_x_o, pixel_y_o
// config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Clear and rejected requests: result strobes in the cycle after start.
// Place: per scanned grid row a RAM read, the column run counters and a shift-and
//   run search on the one shared shifter (doubling steps, then a final step), then
//   read-modify-write marking of each rectangle row and the X and Y multiplications.
// Reset (async, active low) frees the grid at once through per-row valid bits;
//   no clearing pass. busy_o stays high for the whole search; results cannot stall.

module grid_rect_first_fit_packer #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic                            req_type_i,
  input  wire logic [grfp_pkg::DIM_W-1:0]      rect_cols_i,
  input  wire logic [grfp_pkg::DIM_W-1:0]      rect_rows_i,
  // result
  output logic                                 done_o,
  output logic                                 placed_o,
  output logic [grfp_pkg::CELL_W-1:0]          cell_col_o,
  output logic [grfp_pkg::CELL_W-1:0]          cell_row_o,
  output logic [grfp_pkg::POS_W-1:0]           pixel_x_o,
  output logic [grfp_pkg::POS_W-1:0]           pixel_y_o,
  // config
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [grfp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [grfp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDXW  = (CIW > RIW) ? CIW : RIW;
  localparam int DW    = grfp_pkg::DIM_W;
  localparam int SW    = grfp_pkg::SIZE_W;
  localparam int PRODW = IDXW + SW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_UPD,
    ST_DBL,
    ST_FIN,
    ST_CHK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_MUL_X,
    ST_MUL_Y
  } state_e;

  state_e state_q;

  // config registers
  logic [DW-1:0] gcols_q, grows_q;
  logic [SW-1:0] csize_q;

  // control
  logic                done_q;
  logic [MAX_ROWS-1:0] row_vld_q;

  // request and search payload
  logic [DW-1:0]       w_q, h_q, cols_q, rows_q;
  logic [RIW-1:0]      y_q, m_q, row_q;
  logic [CIW-1:0]      col_q;
  logic [DW-1:0]       left_q;
  logic [DW:0]         len_q;
  logic [MAX_COLS-1:0] run_q;
  logic [DW-1:0]       cnt_q [MAX_COLS];
  logic                rvld_q;

  // result payload
  logic                              placed_q;
  logic [grfp_pkg::CELL_W-1:0]       ccol_q, crow_q;
  logic [grfp_pkg::POS_W-1:0]        px_q, py_q;

  // RAM port
  logic                re, we;
  logic [RIW-1:0]      raddr;
  logic [MAX_COLS-1:0] rdata, row_bits, wdata;

  // ---------------------------------------------------------------------------
  // Effective grid size and request check
  // ---------------------------------------------------------------------------
  logic [DW-1:0] cols_eff, rows_eff;
  logic          req_bad;

  assign cols_eff = (9'(gcols_q) > 9'(MAX_COLS)) ? DW'(MAX_COLS) : gcols_q;
  assign rows_eff = (9'(grows_q) > 9'(MAX_ROWS)) ? DW'(MAX_ROWS) : grows_q;
  assign req_bad  = (rect_cols_i == '0) || (rect_rows_i == '0) ||
                    (rect_cols_i > cols_eff) || (rect_rows_i > rows_eff);

  // ---------------------------------------------------------------------------
  // Occupancy store: one word per grid row; rows not yet written since the last
  // clear read as free.
  // ---------------------------------------------------------------------------
  assign re    = (state_q == ST_SCAN_RD) || (state_q == ST_MARK_RD);
  assign raddr = (state_q == ST_MARK_RD) ? m_q : y_q;
  assign we    = (state_q == ST_MARK_WR);

  grfp_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (m_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign row_bits = rvld_q ? rdata : '0;

  // Cells covered by the placed rectangle within one row
  logic [MAX_COLS-1:0] mark_mask;
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      mark_mask[j] = (9'(j) >= 9'(col_q)) && (9'(j) < 9'(col_q) + 9'(w_q));
    end
  end
  assign wdata = row_bits | mark_mask;

  // ---------------------------------------------------------------------------
  // Column lanes: count of free rows ending at the current row; a column can
  // host the rectangle's left edge region once its count reaches the height.
  // ---------------------------------------------------------------------------
  logic [DW-1:0]       cnt_nx [MAX_COLS];
  logic [MAX_COLS-1:0] tall_ok;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (row_bits[c]) begin
        cnt_nx[c] = '0;
      end else if (cnt_q[c] == {DW{1'b1}}) begin
        cnt_nx[c] = cnt_q[c];
      end else begin
        cnt_nx[c] = cnt_q[c] + 1'b1;
      end
      tall_ok[c] = (cnt_nx[c] >= h_q) && (9'(c) < 9'(cols_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Shared shifter: run_q holds bit c set when columns c .. c+len-1 all fit.
  // Doubling steps grow len, the final step tops it up to the rectangle width.
  // ---------------------------------------------------------------------------
  logic [DW:0]         shamt;
  logic [MAX_COLS-1:0] run_nx;

  assign shamt  = (state_q == ST_DBL) ? len_q : ((DW+1)'(w_q) - len_q);
  assign run_nx = run_q & (run_q >> shamt);

  // Lowest fitting column
  logic [CIW-1:0] first_col;
  always_comb begin
    first_col = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (run_q[i]) begin
        first_col = CIW'(i);
      end
    end
  end

  logic [RIW-1:0] origin_row;
  logic           last_row;

  assign origin_row = RIW'(9'(y_q) + 9'd1 - 9'(h_q));
  assign last_row   = (9'(y_q) + 9'd1) >= 9'(rows_q);

  // ---------------------------------------------------------------------------
  // Shared multiplier for pixel positions, saturating at the position width
  // ---------------------------------------------------------------------------
  logic [IDXW-1:0]              mul_a;
  logic [PRODW-1:0]             prod;
  logic [grfp_pkg::POS_W-1:0]   prod_sat;

  assign mul_a    = (state_q == ST_MUL_X) ? IDXW'(col_q) : IDXW'(row_q);
  assign prod     = PRODW'(mul_a) * PRODW'(csize_q);
  assign prod_sat = (32'(prod) > 32'(grfp_pkg::POS_SAT)) ? grfp_pkg::POS_SAT
                                                          : grfp_pkg::POS_W'(prod);

  // ---------------------------------------------------------------------------
  // Sequencer, config registers, valid bits and result strobe
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      row_vld_q <= '0;
      gcols_q   <= grfp_pkg::GRID_DIM_RST;
      grows_q   <= grfp_pkg::GRID_DIM_RST;
      csize_q   <= grfp_pkg::CELL_SIZE_RST;
    end else begin
      done_q <= 1'b0;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          grfp_pkg::CFG_GRID_COLS: gcols_q <= DW'(cfg_data_i);
          grfp_pkg::CFG_GRID_ROWS: grows_q <= DW'(cfg_data_i);
          grfp_pkg::CFG_CELL_SIZE: csize_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            if (!req_type_i) begin
              row_vld_q <= '0;
              done_q    <= 1'b1;
            end else if (req_bad) begin
              done_q <= 1'b1;
            end else begin
              state_q <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: state_q <= ST_SCAN_UPD;
        ST_SCAN_UPD: begin
          state_q <= (w_q >= DW'(2)) ? ST_DBL : ST_FIN;
        end
        ST_DBL: begin
          // stay while the doubled length still fits twice in the width
          if ((9'(len_q) << 2) > 9'(w_q)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: state_q <= ST_CHK;
        ST_CHK: begin
          if (|run_q) begin
            state_q <= ST_MARK_RD;
          end else if (last_row) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_MARK_RD: state_q <= ST_MARK_WR;
        ST_MARK_WR: begin
          row_vld_q[m_q] <= 1'b1;
          state_q        <= (left_q == DW'(1)) ? ST_MUL_X : ST_MARK_RD;
        end
        ST_MUL_X: state_q <= ST_MUL_Y;
        ST_MUL_Y: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (re) begin
      rvld_q <= row_vld_q[raddr];
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          w_q      <= rect_cols_i;
          h_q      <= rect_rows_i;
          cols_q   <= cols_eff;
          rows_q   <= rows_eff;
          y_q      <= '0;
          placed_q <= 1'b0;
          ccol_q   <= '0;
          crow_q   <= '0;
          px_q     <= '0;
          py_q     <= '0;
          for (int c = 0; c < MAX_COLS; c++) begin
            cnt_q[c] <= '0;
          end
        end
      end
      ST_SCAN_UPD: begin
        cnt_q <= cnt_nx;
        run_q <= tall_ok;
        len_q <= (DW+1)'(1);
      end
      ST_DBL: begin
        run_q <= run_nx;
        len_q <= len_q << 1;
      end
      ST_FIN: run_q <= run_nx;
      ST_CHK: begin
        if (|run_q) begin
          col_q  <= first_col;
          row_q  <= origin_row;
          m_q    <= origin_row;
          left_q <= h_q;
        end else begin
          y_q <= y_q + 1'b1;
        end
      end
      ST_MARK_WR: begin
        m_q    <= m_q + 1'b1;
        left_q <= left_q - 1'b1;
      end
      ST_MUL_X: begin
        px_q     <= prod_sat;
        placed_q <= 1'b1;
        ccol_q   <= grfp_pkg::CELL_W'(col_q);
        crow_q   <= grfp_pkg::CELL_W'(row_q);
      end
      ST_MUL_Y: py_q <= prod_sat;
      default: ;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign placed_o    = placed_q;
  assign cell_col_o  = ccol_q;
  assign cell_row_o  = crow_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

import grfp_pkg::*;

typedef enum bit {
  REQ_CLEAR = 1'b0,
  REQ_PLACE = 1'b1
} req_kind_e;

typedef struct {
  logic              placed;
  logic [CELL_W-1:0] col;
  logic [CELL_W-1:0] row;
  logic [POS_W-1:0]  px;
  logic [POS_W-1:0]  py;
} placement_t;

// Occupancy mirror of the packer plus the queue of placements still owed.
class placement_scoreboard #(int COLS_MAX = 64, int ROWS_MAX = 64);
  bit [COLS_MAX-1:0] occupancy [ROWS_MAX];
  int                grid_cols;
  int                grid_rows;
  int                cell_size;
  placement_t        placements_due [$];
  int                errors;

  function new();
    foreach (occupancy[i]) occupancy[i] = '0;
    grid_cols = GRID_DIM_RST;
    grid_rows = GRID_DIM_RST;
    cell_size = CELL_SIZE_RST;
    errors    = 0;
  endfunction

  function int pending();
    return placements_due.size();
  endfunction

  function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GRID_COLS: grid_cols = data[DIM_W-1:0];
      CFG_GRID_ROWS: grid_rows = data[DIM_W-1:0];
      CFG_CELL_SIZE: cell_size = data[SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [POS_W-1:0] scale(int idx);
    longint prod;
    prod = longint'(idx) * longint'(cell_size);
    return (prod > 65535) ? POS_SAT : prod[POS_W-1:0];
  endfunction

  // First fit: rows outer, columns inner, every covered cell must be free.
  function void note_request(req_kind_e kind, bit [DIM_W-1:0] rect_w, bit [DIM_W-1:0] rect_h);
    placement_t        res;
    bit [COLS_MAX-1:0] mask;
    int                cols, rows, w, h, r, c, rr;
    int                hit_r, hit_c;
    bit                found, fits;
    res   = '{1'b0, '0, '0, '0, '0};
    w     = rect_w;
    h     = rect_h;
    cols  = (grid_cols > COLS_MAX) ? COLS_MAX : grid_cols;
    rows  = (grid_rows > ROWS_MAX) ? ROWS_MAX : grid_rows;
    found = 1'b0;
    hit_r = 0;
    hit_c = 0;
    if (kind == REQ_CLEAR) begin
      foreach (occupancy[i]) occupancy[i] = '0;
    end else if (w != 0 && h != 0 && w <= cols && h <= rows) begin
      mask = {COLS_MAX{1'b1}} >> (COLS_MAX - w);
      for (r = 0; r + h <= rows && !found; r++) begin
        for (c = 0; c + w <= cols && !found; c++) begin
          fits = 1'b1;
          for (rr = 0; rr < h && fits; rr++)
            if ((occupancy[r+rr] & (mask << c)) != '0) fits = 1'b0;
          if (fits) begin
            found = 1'b1;
            hit_r = r;
            hit_c = c;
          end
        end
      end
      if (found) begin
        for (rr = 0; rr < h; rr++) occupancy[hit_r+rr] |= mask << hit_c;
        res.placed = 1'b1;
        res.col    = hit_c[CELL_W-1:0];
        res.row    = hit_r[CELL_W-1:0];
        res.px     = scale(hit_c);
        res.py     = scale(hit_r);
      end
    end
    placements_due.insert(placements_due.size(), res);
  endfunction

  function void check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(placement_t got);
    placement_t want;
    if (placements_due.size() == 0) begin
      $display("%0t: result word with nothing outstanding, placed %0b col %0d row %0d",
               $time, got.placed, got.col, got.row);
      errors++;
      return;
    end
    want = placements_due.pop_front();
    check_field("placed",   POS_W'(want.placed), POS_W'(got.placed));
    check_field("cell_col", POS_W'(want.col),    POS_W'(got.col));
    check_field("cell_row", POS_W'(want.row),    POS_W'(got.row));
    check_field("pixel_x",  want.px,             got.px);
    check_field("pixel_y",  want.py,             got.py);
  endfunction
endclass

module tb;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  // Hang guard. Worst case is a full-grid scan per word plus sender idling,
  // taken over every word with plenty of margin.
  localparam int LIMIT    = 40_000_000;
  // Index 3 decodes to no register; writes to it must be harmless.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  req_type_i;
  logic [DIM_W-1:0]      rect_cols_i;
  logic [DIM_W-1:0]      rect_rows_i;
  logic                  done_o;
  logic                  placed_o;
  logic [CELL_W-1:0]     cell_col_o;
  logic [CELL_W-1:0]     cell_row_o;
  logic [POS_W-1:0]      pixel_x_o;
  logic [POS_W-1:0]      pixel_y_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  placement_scoreboard #(MAX_COLS, MAX_ROWS) sb;

  int sender_idle_pct = 0;  // chance (percent) that the sender idles in a cycle
  int sent_count      = 0;  // request words accepted so far
  int cycle_count     = 0;

  grid_rect_first_fit_packer #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_type_i (req_type_i),
    .rect_cols_i(rect_cols_i),
    .rect_rows_i(rect_rows_i),
    .done_o     (done_o),
    .placed_o   (placed_o),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result words live for one cycle only, so they are taken at every edge
  // where the strobe is up; there is no back-pressure to apply.
  always @(posedge clk_i) begin : result_monitor
    placement_t got;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      got.placed = placed_o;
      got.col    = cell_col_o;
      got.row    = cell_row_o;
      got.px     = pixel_x_o;
      got.py     = pixel_y_o;
      sb.check_result(got);
    end
  end

  // One request word. In each cycle the sender may idle with start low;
  // otherwise it offers the word until an edge with busy low takes it.
  // start is left high on return so back-to-back words need no extra edge.
  task automatic send_word(req_kind_e kind, int w, int h);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        start_i     <= 1'b1;
        req_type_i  <= kind;
        rect_cols_i <= w[DIM_W-1:0];
        rect_rows_i <= h[DIM_W-1:0];
        @(posedge clk_i);
        taken = (busy_o === 1'b0);
      end
    end
    sb.note_request(kind, w[DIM_W-1:0], h[DIM_W-1:0]);
    sent_count++;
  endtask

  // Drop start and wait until every outstanding word has come back.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Register write; only called once the packer has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.note_config(idx, data[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Grid dimension: edges, above the maximum, empty, tiny and mid sizes.
  // The unused upper data bits are sometimes set as well.
  function automatic int dim_word();
    int dim;
    int hi;
    case ($urandom_range(9))
      0:       dim = 1;
      1:       dim = 64;
      2:       dim = $urandom_range(65, 127);
      3:       dim = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 7);
      default: dim = $urandom_range(8, 64);
    endcase
    hi = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
    return hi * 128 + dim;
  endfunction

  function automatic int size_word();
    case ($urandom_range(5))
      0:       return 1;
      1:       return 1024;
      2:       return 2047;   // past the nominal range: saturating positions
      3:       return $urandom_range(1, 2047);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  task automatic new_settings();
    write_reg(CFG_GRID_COLS, dim_word());
    write_reg(CFG_GRID_ROWS, dim_word());
    write_reg(CFG_CELL_SIZE, size_word());
    if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, $urandom_range(2047));
  endtask

  // Mostly small rectangles that pack densely, some big ones, and a little
  // noise: zero or oversized dimensions and stray clears.
  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5)
      send_word(REQ_CLEAR, $urandom_range(127), $urandom_range(127));
    else if (pick < 10)
      send_word(REQ_PLACE, $urandom_range(127), $urandom_range(127));
    else if (pick < 25)
      send_word(REQ_PLACE, $urandom_range(1, 64), $urandom_range(1, 64));
    else
      send_word(REQ_PLACE, $urandom_range(1, 8), $urandom_range(1, 8));
  endtask

  // A packing session: normally starts from an empty grid. Skipping the clear
  // now and then keeps cells left over from an earlier, larger grid.
  task automatic episode();
    int n;
    n = $urandom_range(5, 40);
    if ($urandom_range(9) != 0)
      send_word(REQ_CLEAR, $urandom_range(127), $urandom_range(127));
    repeat (n) random_word();
  endtask

  initial begin
    int idle_pct [3];
    int target;
    idle_pct[0] = 18;
    idle_pct[1] = 58;
    idle_pct[2] = 0;
    sb          = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = 1'b0;
    rect_cols_i = '0;
    rect_rows_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset settings, 64 x 64 grid, 16 px cells.
    send_word(REQ_PLACE, 1, 1);       // first origin
    send_word(REQ_PLACE, 64, 64);     // blocked by the single cell
    send_word(REQ_CLEAR, 127, 127);
    send_word(REQ_PLACE, 64, 64);     // whole grid
    send_word(REQ_PLACE, 1, 1);       // grid full
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_PLACE, 0, 3);       // zero width
    send_word(REQ_PLACE, 3, 0);       // zero height
    send_word(REQ_PLACE, 65, 1);      // wider than the grid
    send_word(REQ_PLACE, 127, 127);
    send_word(REQ_PLACE, 63, 2);
    send_word(REQ_PLACE, 1, 1);       // last column
    send_word(REQ_PLACE, 1, 1);       // wraps to the next row
    send_word(REQ_PLACE, 2, 2);
    drain();

    // Oversized grid registers clamp; widest cells saturate pixel positions.
    write_reg(CFG_CELL_SIZE, 2047);
    write_reg(CFG_GRID_COLS, 127);
    write_reg(CFG_GRID_ROWS, 127);
    write_reg(CFG_UNUSED, 2047);
    send_word(REQ_CLEAR, 64, 64);
    send_word(REQ_PLACE, 63, 1);
    send_word(REQ_PLACE, 1, 1);       // column 63 times 2047 saturates
    send_word(REQ_PLACE, 1, 64);      // row 0 is full, nothing fits
    send_word(REQ_PLACE, 1, 63);
    drain();

    // Empty grid, then a 1 x 1 grid over cells left occupied from before.
    write_reg(CFG_GRID_COLS, 0);
    send_word(REQ_PLACE, 1, 1);
    drain();
    write_reg(CFG_GRID_COLS, 1);
    write_reg(CFG_GRID_ROWS, 1);
    write_reg(CFG_CELL_SIZE, 1);
    send_word(REQ_PLACE, 1, 1);       // stale bit at the origin blocks it
    send_word(REQ_CLEAR, 1, 1);
    send_word(REQ_PLACE, 1, 1);
    send_word(REQ_PLACE, 1, 1);
    drain();

    // Random: three sender idling regimes, settings changed between sessions.
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = idle_pct[p];
      target = sent_count + 575;
      while (sent_count < target) begin
        drain();
        new_settings();
        repeat ($urandom_range(2, 6)) if (sent_count < target) episode();
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/grfp_pkg.sv
sv/grfp_ram.sv
sv/grid_rect_first_fit_packer.sv
test/tb.sv
